FILE: src/egcd_pkg.sv
package egcd_pkg;

  // Default operand width of the block.
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Commands from the sequencer to the shared divider.
  typedef struct packed {
    logic load;  // Load fresh magnitudes and clear the partial remainder.
    logic step;  // Produce one quotient bit.
  } div_ctl_t;

  // Commands from the sequencer to the coefficient unit.
  typedef struct packed {
    logic init;    // Start a new item: p = 0, q = 1, p_prev = 1, q_prev = 0.
    logic step;    // Fold one quotient bit into the running products.
    logic commit;  // Apply the products and rotate the coefficient pairs.
    logic neg;     // The signed quotient of this round is negative.
  } coef_ctl_t;

endpackage

FILE: src/egcd_if.sv
// Input channel: one word carries an operand pair.
interface egcd_in_if
  import egcd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a_value;
  logic signed [DATA_WIDTH-1:0] b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink (input valid, input a_value, input b_value, output ready);
endinterface

// Output channel: one word carries the coefficients, the gcd and the error flag.
interface egcd_out_if
  import egcd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] coef_a;
  logic signed [DATA_WIDTH-1:0] coef_b;
  logic signed [DATA_WIDTH-1:0] gcd_value;
  logic                         div_zero_error;

  modport source (
    output valid, output coef_a, output coef_b, output gcd_value,
    output div_zero_error, input ready
  );
  modport sink (
    input valid, input coef_a, input coef_b, input gcd_value,
    input div_zero_error, output ready
  );
endinterface

FILE: src/extended_gcd_bezout.sv
// Extended Euclid engine: for one signed operand pair (a, b) it returns p, q and
// r with a*p + b*q = r, r being the gcd with the sign that truncating division
// gives (the sign of the last nonzero remainder). If the first remainder is
// already zero the result is p = 0, q = 1, r = b. If b is zero the word comes
// back with all three values zero and div_zero_error set, without any division.
// One pair is processed at a time and the input is not ready while it runs.
// Each Euclid round runs the bit-serial restoring divider, which also feeds
// the quotient bits into the coefficient accumulators, and then checks the
// remainder and commits the round. A finished word sits in an output
// register, and the next pair is accepted while it waits to be taken.
module extended_gcd_bezout
  import egcd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  egcd_in_if.sink          in_i,
  egcd_out_if.source       out_o
);

  localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;

  // Operands of the current round; a_q is only needed for the first division.
  logic [DATA_WIDTH-1:0] a_q, a_d;
  logic [DATA_WIDTH-1:0] b_q, b_d;
  logic                  n_neg_q, n_neg_d;
  logic                  d_neg_q, d_neg_d;
  logic                  err_q, err_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_a_q, out_a_d;
  logic [DATA_WIDTH-1:0] out_b_q, out_b_d;
  logic [DATA_WIDTH-1:0] out_r_q, out_r_d;
  logic                  out_err_q, out_err_d;

  div_ctl_t              div_ctl;
  coef_ctl_t             coef_ctl;
  logic [DATA_WIDTH-1:0] div_num, div_den;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] rem_mag;
  logic [DATA_WIDTH-1:0] rem_signed;
  logic [DATA_WIDTH-1:0] a_mag, b_mag;
  logic [DATA_WIDTH-1:0] coef_p, coef_q;

  egcd_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk_i (clk_i),
    .ctl_i (div_ctl),
    .num_i (div_num),
    .den_i (div_den),
    .qbit_o(qbit),
    .rem_o (rem_mag)
  );

  egcd_coef #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_coef (
    .clk_i (clk_i),
    .ctl_i (coef_ctl),
    .qbit_i(qbit),
    .p_o   (coef_p),
    .q_o   (coef_q)
  );

  // Magnitudes are exact in DATA_WIDTH unsigned bits, even for the most negative value.
  assign a_mag      = a_q[DATA_WIDTH-1] ? ('0 - a_q) : a_q;
  assign b_mag      = b_q[DATA_WIDTH-1] ? ('0 - b_q) : b_q;
  // The remainder takes the sign of the dividend.
  assign rem_signed = n_neg_q ? ('0 - rem_mag) : rem_mag;

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.coef_a         = out_a_q;
  assign out_o.coef_b         = out_b_q;
  assign out_o.gcd_value      = out_r_q;
  assign out_o.div_zero_error = out_err_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    a_d         = a_q;
    b_d         = b_q;
    n_neg_d     = n_neg_q;
    d_neg_d     = d_neg_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_a_d     = out_a_q;
    out_b_d     = out_b_q;
    out_r_d     = out_r_q;
    out_err_d   = out_err_q;
    div_ctl     = '0;
    coef_ctl    = '0;
    div_num     = a_mag;
    div_den     = b_mag;

    // The consumer takes the waiting word.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          a_d   = in_i.a_value;
          b_d   = in_i.b_value;
          err_d = (in_i.b_value == '0);
          state_d = (in_i.b_value == '0) ? ST_FIN : ST_START;
        end
      end
      ST_START: begin
        div_ctl.load  = 1'b1;
        coef_ctl.init = 1'b1;
        n_neg_d       = a_q[DATA_WIDTH-1];
        d_neg_d       = b_q[DATA_WIDTH-1];
        cnt_d         = '0;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        div_ctl.step  = 1'b1;
        coef_ctl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CW'(DATA_WIDTH - 1)) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (rem_mag == '0) begin
          // The current divisor is the gcd and the coefficients stand as they are.
          state_d = ST_FIN;
        end else begin
          // Rotate: the divisor becomes the dividend, the remainder the divisor.
          coef_ctl.commit = 1'b1;
          coef_ctl.neg    = n_neg_q ^ d_neg_q;
          div_ctl.load    = 1'b1;
          div_num         = b_mag;
          div_den         = rem_mag;
          a_d             = b_q;
          b_d             = rem_signed;
          n_neg_d         = b_q[DATA_WIDTH-1];
          d_neg_d         = n_neg_q;
          cnt_d           = '0;
          state_d         = ST_DIV;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_a_d     = err_q ? '0 : coef_p;
          out_b_d     = err_q ? '0 : coef_q;
          out_r_d     = err_q ? '0 : b_q;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    n_neg_q   <= n_neg_d;
    d_neg_q   <= d_neg_d;
    err_q     <= err_d;
    out_a_q   <= out_a_d;
    out_b_q   <= out_b_d;
    out_r_q   <= out_r_d;
    out_err_q <= out_err_d;
  end

  // A zero-divisor word carries zeros in all value fields.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_a_q == '0 && out_b_q == '0 && out_r_q == '0)
    else $error("error word with nonzero values");

  // A regular result never reports a zero gcd.
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_err_q |-> out_r_q != '0)
    else $error("zero gcd without error flag");

  // After a full division the remainder is below the divisor, so the rounds shrink.
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHK |-> rem_mag < b_mag)
    else $error("divider remainder not below divisor");

  // A new word appears only from the finish state.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("output word loaded outside finish state");

  // The division counter never runs past the operand width.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q < CW'(DATA_WIDTH))
    else $error("division step counter out of range");

endmodule

FILE: src/egcd_div.sv
// Restoring divider on unsigned magnitudes, one quotient bit per step, MSB first.
module egcd_div
  import egcd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  div_ctl_t              ctl_i,
  input  logic [DATA_WIDTH-1:0] num_i,
  input  logic [DATA_WIDTH-1:0] den_i,
  output logic                  qbit_o,
  output logic [DATA_WIDTH-1:0] rem_o
);

  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] num_q, num_d;
  logic [DATA_WIDTH-1:0] den_q, den_d;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   trial;

  assign shifted = {rem_q, num_q[DATA_WIDTH-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign qbit_o  = ~trial[DATA_WIDTH];
  assign rem_o   = rem_q;

  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    den_d = den_q;
    if (ctl_i.load) begin
      rem_d = '0;
      num_d = num_i;
      den_d = den_i;
    end else if (ctl_i.step) begin
      rem_d = qbit_o ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      num_d = {num_q[DATA_WIDTH-2:0], qbit_o};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

endmodule

FILE: src/egcd_coef.sv
// Bezout coefficient pairs. The products p*quo and q*quo are built by Horner's
// rule from the quotient bits as the divider emits them, so a round needs no
// multiplier; all arithmetic wraps modulo 2^DATA_WIDTH.
module egcd_coef
  import egcd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  coef_ctl_t             ctl_i,
  input  logic                  qbit_i,
  output logic [DATA_WIDTH-1:0] p_o,
  output logic [DATA_WIDTH-1:0] q_o
);

  logic [DATA_WIDTH-1:0] p_q, p_d, q_q, q_d;
  logic [DATA_WIDTH-1:0] pp_q, pp_d, qp_q, qp_d;
  logic [DATA_WIDTH-1:0] tp_q, tp_d, tq_q, tq_d;

  assign p_o = p_q;
  assign q_o = q_q;

  always_comb begin
    p_d  = p_q;
    q_d  = q_q;
    pp_d = pp_q;
    qp_d = qp_q;
    tp_d = tp_q;
    tq_d = tq_q;
    if (ctl_i.init) begin
      p_d  = '0;
      q_d  = DATA_WIDTH'(1);
      pp_d = DATA_WIDTH'(1);
      qp_d = '0;
      tp_d = '0;
      tq_d = '0;
    end else if (ctl_i.commit) begin
      // A negative quotient turns the subtraction of the magnitude product into an add.
      p_d  = ctl_i.neg ? (pp_q + tp_q) : (pp_q - tp_q);
      q_d  = ctl_i.neg ? (qp_q + tq_q) : (qp_q - tq_q);
      pp_d = p_q;
      qp_d = q_q;
      tp_d = '0;
      tq_d = '0;
    end else if (ctl_i.step) begin
      tp_d = {tp_q[DATA_WIDTH-2:0], 1'b0} + (qbit_i ? p_q : '0);
      tq_d = {tq_q[DATA_WIDTH-2:0], 1'b0} + (qbit_i ? q_q : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    q_q  <= q_d;
    pp_q <= pp_d;
    qp_q <= qp_d;
    tp_q <= tp_d;
    tq_q <= tq_d;
  end

endmodule
